@@ rtl/csl_pkg.sv @@
// shared types, codes and constants for the character stream lexer
package csl_pkg;

    localparam int MAX_IDENT_LEN = 255;
    localparam int POS_BITS      = 16;

    localparam int KIND_W  = 4;
    localparam int VALUE_W = 32;
    localparam int START_W = 16;
    localparam int LEN_W   = 8;
    localparam int CHAR_W  = 8;

    // output tdata width, fields padded up to whole bytes
    localparam int OUT_FIELD_W = KIND_W + VALUE_W + START_W + LEN_W;
    localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

    // token kinds
    localparam logic [KIND_W-1:0] KIND_NUMBER    = 4'd0;
    localparam logic [KIND_W-1:0] KIND_IDENT     = 4'd1;
    localparam logic [KIND_W-1:0] KIND_VAR       = 4'd2;
    localparam logic [KIND_W-1:0] KIND_PLUS      = 4'd3;
    localparam logic [KIND_W-1:0] KIND_MINUS     = 4'd4;
    localparam logic [KIND_W-1:0] KIND_TIMES     = 4'd5;
    localparam logic [KIND_W-1:0] KIND_DIVIDE    = 4'd6;
    localparam logic [KIND_W-1:0] KIND_ASSIGN    = 4'd7;
    localparam logic [KIND_W-1:0] KIND_END       = 4'd8;
    localparam logic [KIND_W-1:0] KIND_INVALID   = 4'd9;
    localparam logic [KIND_W-1:0] KIND_TOO_LONG  = 4'd10;

    // scan modes
    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_NUM    = 2'd1;
    localparam logic [1:0] MODE_IDENT  = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // source characters
    localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
    localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2b;
    localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2d;
    localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2a;
    localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2f;
    localparam logic [CHAR_W-1:0] CH_EQUAL  = 8'h3d;
    localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR     = 8'h0d;
    localparam logic [CHAR_W-1:0] CH_LOW_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOW_Z  = 8'h7a;
    localparam logic [CHAR_W-1:0] CH_UP_A   = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UP_Z   = 8'h5a;
    localparam logic [CHAR_W-1:0] CH_V      = 8'h76;
    localparam logic [CHAR_W-1:0] CH_A      = 8'h61;
    localparam logic [CHAR_W-1:0] CH_R      = 8'h72;

    localparam logic [LEN_W-1:0] LEN_SAT = 8'd255;

    typedef struct packed {
        logic               last;
        logic [LEN_W-1:0]   len;
        logic [START_W-1:0] start;
        logic signed [VALUE_W-1:0] value;
        logic [KIND_W-1:0]  kind;
    } token_t;

    // character of the var keyword at a given index
    function automatic logic [CHAR_W-1:0] var_char(input logic [1:0] idx);
        logic [CHAR_W-1:0] ch;
        case (idx)
            2'd0:    ch = CH_V;
            2'd1:    ch = CH_A;
            2'd2:    ch = CH_R;
            default: ch = CH_NUL;
        endcase
        return ch;
    endfunction

endpackage

@@ rtl/char_stream_lexer.sv @@
// character stream lexer: one source byte per transaction, token stream out
// a token caused by a character is written to the token queue when the character is taken
// throughput: one character per cycle while the output keeps up; a character that
// closes a run and is itself a token produces two output transactions
// a four-entry token queue decouples the sides; input is taken while two slots are free
// reset (rst_n low, asynchronous) clears scan state, position and the queue
module char_stream_lexer
    import csl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [CHAR_W-1:0]     s_axis_tdata,   // source_char
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // token_kind, number_value, start_pos,
                                                  // token_length, zero pad
    output logic                  m_axis_tlast    // last_of_run
);

    logic [1:0]          mode_reg, mode_next;
    logic [VALUE_W-1:0]  acc_reg, acc_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic                ovf_reg, ovf_next;
    logic                match_reg, match_next;
    logic [POS_BITS-1:0] start_reg, start_next;
    logic [POS_BITS-1:0] pos_reg, pos_next;

    token_t              queue_mem [4];
    logic [1:0]          wr_ptr_reg, rd_ptr_reg;
    logic [2:0]          count_reg;

    logic                s_acc, m_acc;
    logic [CHAR_W-1:0]   ch;
    logic                is_digit, is_alpha, is_space;
    logic                run_emit, char_emit;
    token_t              run_tok, char_tok, tok0, tok1;
    logic [1:0]          n_tok;
    logic [LEN_W-1:0]    len_inc;
    logic [KIND_W-1:0]   op_kind;

    assign s_acc = s_axis_tvalid && s_axis_tready;
    assign m_acc = m_axis_tvalid && m_axis_tready;
    assign ch    = s_axis_tdata;

    assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign is_alpha = ((ch >= CH_LOW_A) && (ch <= CH_LOW_Z))
                   || ((ch >= CH_UP_A) && (ch <= CH_UP_Z));
    assign is_space = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
    assign len_inc  = (len_reg < LEN_SAT) ? len_reg + 8'd1 : len_reg;

    always_comb
    begin
        unique case (ch)
            CH_PLUS:  op_kind = KIND_PLUS;
            CH_MINUS: op_kind = KIND_MINUS;
            CH_STAR:  op_kind = KIND_TIMES;
            CH_SLASH: op_kind = KIND_DIVIDE;
            CH_EQUAL: op_kind = KIND_ASSIGN;
            default:  op_kind = KIND_INVALID;
        endcase
    end

    always_comb
    begin
        mode_next  = mode_reg;
        acc_next   = acc_reg;
        len_next   = len_reg;
        ovf_next   = ovf_reg;
        match_next = match_reg;
        start_next = start_reg;
        pos_next   = pos_reg;
        run_emit   = 1'b0;
        char_emit  = 1'b0;

        run_tok.last  = 1'b0;
        run_tok.len   = len_reg;
        run_tok.start = START_W'(start_reg);
        run_tok.value = '0;
        run_tok.kind  = KIND_IDENT;

        char_tok.last  = 1'b0;
        char_tok.len   = 8'd1;
        char_tok.start = START_W'(pos_reg);
        char_tok.value = '0;
        char_tok.kind  = op_kind;

        if (mode_reg == MODE_NUM && is_digit)
        begin
            acc_next = {acc_reg[VALUE_W-4:0], 3'b000} + {acc_reg[VALUE_W-2:0], 1'b0}
                     + VALUE_W'(ch[3:0]);
            len_next = len_inc;
            pos_next = pos_reg + POS_BITS'(1);
        end
        else if (mode_reg == MODE_IDENT && (is_alpha || is_digit))
        begin
            if (len_reg < 8'd3)
                match_next = match_reg && (ch == var_char(len_reg[1:0]));
            else
                match_next = 1'b0;
            if (32'(len_reg) >= MAX_IDENT_LEN)
                ovf_next = 1'b1;
            len_next = len_inc;
            pos_next = pos_reg + POS_BITS'(1);
        end
        else
        begin
            // the run, if any, is closed by this character
            if (mode_reg == MODE_NUM)
            begin
                run_emit      = 1'b1;
                run_tok.kind  = KIND_NUMBER;
                run_tok.value = acc_reg;
            end
            else if (mode_reg == MODE_IDENT)
            begin
                run_emit = 1'b1;
                if (ovf_reg)
                    run_tok.kind = KIND_TOO_LONG;
                else if (match_reg && len_reg == 8'd3)
                    run_tok.kind = KIND_VAR;
                else
                    run_tok.kind = KIND_IDENT;
            end
            mode_next = MODE_IDLE;

            if (ch == CH_NUL)
            begin
                char_emit     = 1'b1;
                char_tok.kind = KIND_END;
                char_tok.len  = '0;
            end
            else if (is_space)
            begin
                pos_next = pos_reg + POS_BITS'(1);
            end
            else if (is_digit)
            begin
                mode_next  = MODE_NUM;
                acc_next   = VALUE_W'(ch[3:0]);
                len_next   = 8'd1;
                start_next = pos_reg;
                pos_next   = pos_reg + POS_BITS'(1);
            end
            else if (is_alpha)
            begin
                mode_next  = MODE_IDENT;
                acc_next   = '0;
                len_next   = 8'd1;
                ovf_next   = 1'b0;
                match_next = (ch == CH_V);
                start_next = pos_reg;
                pos_next   = pos_reg + POS_BITS'(1);
            end
            else
            begin
                char_emit = 1'b1;
                pos_next  = pos_reg + POS_BITS'(1);
            end
        end

        // order results: closed run first, then the character's own token
        tok0 = run_emit ? run_tok : char_tok;
        tok1 = char_tok;
        n_tok = 2'(run_emit) + 2'(char_emit);
        tok0.last = (n_tok == 2'd1);
        tok1.last = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            acc_reg   <= '0;
            len_reg   <= '0;
            ovf_reg   <= 1'b0;
            match_reg <= 1'b0;
            start_reg <= '0;
            pos_reg   <= '0;
        end
        else if (s_acc)
        begin
            mode_reg  <= mode_next;
            acc_reg   <= acc_next;
            len_reg   <= len_next;
            ovf_reg   <= ovf_next;
            match_reg <= match_next;
            start_reg <= start_next;
            pos_reg   <= pos_next;
        end
    end

    // token queue
    always_ff @(posedge clk)
    begin
        if (s_acc && n_tok != 2'd0)
        begin
            queue_mem[wr_ptr_reg] <= tok0;
            if (n_tok == 2'd2)
                queue_mem[wr_ptr_reg + 2'd1] <= tok1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (s_acc)
                wr_ptr_reg <= wr_ptr_reg + n_tok;
            if (m_acc)
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            count_reg <= count_reg + (s_acc ? 3'(n_tok) : 3'd0) - 3'(m_acc);
        end
    end

    assign s_axis_tready = (count_reg <= 3'd2);
    assign m_axis_tvalid = (count_reg != 3'd0);
    assign m_axis_tdata  = OUT_DATA_W'({queue_mem[rd_ptr_reg].len,
                                        queue_mem[rd_ptr_reg].start,
                                        queue_mem[rd_ptr_reg].value,
                                        queue_mem[rd_ptr_reg].kind});
    assign m_axis_tlast  = queue_mem[rd_ptr_reg].last;

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 3'd4)
        else $error("token queue overfilled");

    a_nul_holds_pos: assert property (@(posedge clk) disable iff (!rst_n)
        s_acc && s_axis_tdata == CH_NUL |=> $stable(pos_reg))
        else $error("position moved on end of input");

    a_mode_legal: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg != MODE_UNUSED)
        else $error("unused scan mode entered");

    a_ovf_len: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg && mode_reg == MODE_IDENT |-> 32'(len_reg) >= MAX_IDENT_LEN)
        else $error("identifier overflow flag without long identifier");

endmodule
